// File: hdl/profile_undistort_homography_defines.svh
// assertion macros for the profile undistortion block
`ifndef PROFILE_UNDISTORT_HOMOGRAPHY_DEFINES_SVH
`define PROFILE_UNDISTORT_HOMOGRAPHY_DEFINES_SVH
`ifndef ASSERT_OFF
`define PUH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl failed");
`define PUH_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`else
`define PUH_ASSERT(lbl, prop)
`define PUH_ASSERT_RST(lbl, prop)
`endif
`endif

// File: hdl/puh_pkg.sv
// ----------------------------------------------------------------------------
// puh_pkg
// shared types and constants of the profile undistortion block
// ----------------------------------------------------------------------------
package puh_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 512;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int AddrW     = ColW + RowW;
  localparam int Depth     = MaxWidth * MaxHeight;

  localparam logic [1:0] REQ_MAP    = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MARKER = 2'd2;

  typedef struct packed {
    logic [9:0]  column;
    logic [23:0] range_value;
    logic        last;
  } sample_t;
endpackage

// File: hdl/puh_ram.sv
// ----------------------------------------------------------------------------
// puh_ram
// generic single-port write, single-port registered read memory
// ----------------------------------------------------------------------------
module puh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule

// File: hdl/puh_front.sv
// ----------------------------------------------------------------------------
// puh_front
// accepts requests, performs table loads and queues samples for the back end
// ----------------------------------------------------------------------------
module puh_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [1:0]                 req_type,
  input  logic [18:0]                map_index,
  input  logic [23:0]                map_dx,
  input  logic [23:0]                map_dy,
  input  logic [3:0]                 coef_index,
  input  logic [47:0]                coef_value,
  input  puh_pkg::sample_t           in_sample,
  input  logic                       back_idle,
  output logic                       map_we,
  output logic [puh_pkg::AddrW-1:0]  map_waddr,
  output logic [47:0]                map_wdata,
  output logic                       coef_we,
  output logic [3:0]                 coef_waddr,
  output logic [47:0]                coef_wdata,
  output logic                       q_valid,
  input  logic                       q_ready,
  output puh_pkg::sample_t           q_sample
);
  puh_pkg::sample_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       acc, push, pop;

  // loads wait until no sample is queued or in progress
  assign in_tready = (cnt_r != 2'd2) &&
                     ((req_type == puh_pkg::REQ_SAMPLE) || ((cnt_r == 2'd0) && back_idle));
  assign acc  = in_tvalid && in_tready;
  assign push = acc && (req_type == puh_pkg::REQ_SAMPLE);
  assign pop  = q_valid && q_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_sample = q_r[rd_r];

  assign map_we    = acc && (req_type == puh_pkg::REQ_MAP) &&
                     ({13'd0, map_index} < 32'(puh_pkg::Depth));
  assign map_waddr = map_index[puh_pkg::AddrW-1:0];
  assign map_wdata = {map_dy, map_dx};
  assign coef_we    = acc && (req_type == puh_pkg::REQ_COEF) && (coef_index < 4'd9);
  assign coef_waddr = coef_index;
  assign coef_wdata = coef_value;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) q_r[wr_r] <= in_sample;
  end
endmodule

// File: hdl/puh_div.sv
// ----------------------------------------------------------------------------
// puh_div
// radix-2 restoring divider, rounded and saturated to signed q16.16
// ----------------------------------------------------------------------------
module puh_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic [31:0]        quot
);
  logic [79:0] dvd_r, dvd_nxt;
  logic [64:0] rem_r, rem_nxt, rsh;
  logic [63:0] ud_r;
  logic [40:0] q_r, q_nxt;
  logic        sat_r, sat_nxt, neg_r, busy_r;
  logic [6:0]  cnt_r;
  logic [63:0] un, ud;
  logic [40:0] qr;
  logic [31:0] mag;

  assign un = num[63] ? 64'(-num) : 64'(num);
  assign ud = den[63] ? 64'(-den) : 64'(den);

  always_comb begin
    rsh     = {rem_r[63:0], dvd_r[79]};
    dvd_nxt = {dvd_r[78:0], 1'b0};
    q_nxt   = {q_r[39:0], 1'b0};
    rem_nxt = rsh;
    sat_nxt = sat_r;
    if (rsh >= {1'b0, ud_r}) begin
      rem_nxt = rsh - {1'b0, ud_r};
      q_nxt[0] = 1'b1;
    end
    if (q_nxt[40]) begin
      sat_nxt = 1'b1;
      q_nxt[40] = 1'b0;
    end
  end

  always_comb begin
    qr  = q_r + {40'd0, (rem_r >= ({1'b0, ud_r} - rem_r))};
    mag = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (!sat_r && (qr <= {9'd0, mag})) mag = qr[31:0];
    quot = neg_r ? 32'(-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd79;
      end else if (busy_r) begin
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
        cnt_r <= cnt_r - 7'd1;
      end
    end
    if (start) begin
      dvd_r <= {un, 16'd0};
      ud_r  <= ud;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
      neg_r <= num[63] ^ den[63];
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      sat_r <= sat_nxt;
    end
  end
endmodule

// File: hdl/puh_back.sv
// ----------------------------------------------------------------------------
// puh_back
// two map correction passes, homography sums and the two divisions
// ----------------------------------------------------------------------------
`include "profile_undistort_homography_defines.svh"
module puh_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [10:0]                width_r,
  input  logic [9:0]                 height_r,
  input  logic [31:0]                marker_r,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  puh_pkg::sample_t           q_sample,
  output logic [puh_pkg::AddrW-1:0]  map_raddr,
  input  logic [47:0]                map_rdata,
  output logic [3:0]                 coef_raddr,
  input  logic [47:0]                coef_rdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [74:0]                out_tdata,
  output logic                       out_tlast
);
  localparam logic [3:0] S_IDLE = 4'd0, S_ADDR = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
                         S_MAP = 4'd4, S_CF = 4'd5, S_MUL = 4'd6, S_ACC = 4'd7,
                         S_DIVX = 4'd8, S_DIVZ = 4'd9, S_OUT = 4'd10, S_CRD = 4'd11;
  logic [3:0]  st_r;
  puh_pkg::sample_t smp_r;
  logic [10:0] w;
  logic [9:0]  h;
  logic signed [25:0] sx, sy, cx_r, cy_r;
  logic        pass_r;
  logic [puh_pkg::ColW-1:0] ix;
  logic [puh_pkg::RowW-1:0] iy;
  logic [puh_pkg::AddrW-1:0] addr_r;
  logic [3:0]  k_r;
  logic signed [47:0] hc_r;
  logic signed [63:0] prod_r, acc_r, nx_r, nz_r, den_r;
  logic signed [31:0] hh;
  logic [15:0] hl;
  logic signed [25:0] opnd;
  logic signed [63:0] pa, pb;
  logic        div_start, div_done;
  logic signed [63:0] div_num;
  logic [31:0] div_q, wx_r;
  logic        valid_r;

  assign w  = (width_r == 11'd0) ? 11'd1 :
              (width_r > 11'(puh_pkg::MaxWidth)) ? 11'(puh_pkg::MaxWidth) : width_r;
  assign h  = (height_r == 10'd0) ? 10'd1 :
              ({1'b0, height_r} > 11'(puh_pkg::MaxHeight)) ? 10'(puh_pkg::MaxHeight)
              : height_r;
  assign sx = {5'd0, smp_r.column, 11'd0};
  assign sy = {2'd0, smp_r.range_value};

  always_comb begin
    if (cx_r < 0) ix = '0;
    else if (cx_r >= $signed({4'd0, w, 11'd0})) ix = puh_pkg::ColW'(w - 11'd1);
    else ix = puh_pkg::ColW'(cx_r[25:11]);
    if (cy_r < 0) iy = '0;
    else if (cy_r >= $signed({5'd0, h, 11'd0})) iy = puh_pkg::RowW'(h - 10'd1);
    else iy = puh_pkg::RowW'(cy_r[25:11]);
  end
  assign map_raddr  = addr_r;
  assign coef_raddr = k_r;

  // q.32 coefficient times q.11 value, floor split into high and low parts
  assign hh   = 32'(hc_r >>> 16);
  assign hl   = hc_r[15:0];
  assign opnd = (k_r == 4'd0 || k_r == 4'd3 || k_r == 4'd6) ? cx_r : cy_r;
  assign pa   = 64'(hh * opnd) <<< 5;
  assign pb   = 64'($signed({1'b0, hl}) * opnd) >>> 11;

  assign div_num = (st_r == S_DIVX) ? nx_r : nz_r;
  puh_div u_div (.clk, .rst_n, .start(div_start), .num(div_num), .den(den_r),
                 .done(div_done), .quot(div_q));

  assign q_ready    = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tlast  = smp_r.last;
  assign out_tdata  = {valid_r, valid_r ? div_q : marker_r,
                       valid_r ? wx_r : marker_r, smp_r.column};

  logic div_go_r;
  assign div_start = div_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          st_r   <= S_ADDR;
          pass_r <= 1'b0;
        end
        S_ADDR: st_r <= S_RD;
        S_RD:   st_r <= S_RDW;
        S_RDW:  st_r <= S_MAP;
        S_MAP:  st_r <= pass_r ? S_CF : S_ADDR;
        S_CRD:  st_r <= S_CF;
        S_CF:   st_r <= S_MUL;
        S_MUL:  st_r <= S_ACC;
        S_ACC: begin
          if (k_r == 4'd5) begin
            st_r     <= S_DIVX;
            div_go_r <= 1'b1;
          end else st_r <= S_CRD;
        end
        S_DIVX: if (div_done) begin
          st_r     <= S_DIVZ;
          div_go_r <= 1'b1;
        end
        S_DIVZ: if (div_done) st_r <= S_OUT;
        S_OUT:  if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
    case (st_r)
      S_IDLE: begin
        smp_r <= q_sample;
        cx_r  <= {5'd0, q_sample.column, 11'd0};
        cy_r  <= {2'd0, q_sample.range_value};
        k_r   <= 4'd6;
        acc_r <= '0;
      end
      S_ADDR: addr_r <= puh_pkg::AddrW'(iy * w) + puh_pkg::AddrW'(ix);
      S_MAP: begin
        cx_r   <= sx - 26'($signed(map_rdata[23:0]));
        cy_r   <= sy - 26'($signed(map_rdata[47:24]));
        pass_r <= 1'b1;
      end
      S_CF:  hc_r <= coef_rdata;
      S_MUL: prod_r <= (k_r == 4'd2 || k_r == 4'd5 || k_r == 4'd8) ?
                       64'(hc_r) : pa + pb;
      S_ACC: begin
        if (k_r == 4'd8 || k_r == 4'd2 || k_r == 4'd5) acc_r <= '0;
        else acc_r <= acc_r + prod_r;
        if (k_r == 4'd8) begin
          den_r   <= acc_r + prod_r;
          valid_r <= (smp_r.range_value != 24'd0) && ((acc_r + prod_r) != 64'd0);
          k_r     <= 4'd0;
        end else if (k_r == 4'd2) begin
          nx_r <= acc_r + prod_r;
          k_r  <= 4'd3;
        end else if (k_r == 4'd5) begin
          nz_r <= acc_r + prod_r;
          k_r  <= 4'd8;
        end else k_r <= k_r + 4'd1;
      end
      S_DIVX: if (div_done) wx_r <= div_q;
      default: ;
    endcase
  end

  `PUH_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `PUH_ASSERT(a_pop_idle, q_valid && q_ready |=> st_r == S_ADDR)
  `PUH_ASSERT(a_div_start, div_start |-> st_r == S_DIVX || st_r == S_DIVZ)
  `PUH_ASSERT_RST(a_rst, !rst_n |=> !out_tvalid)
endmodule

// File: hdl/profile_undistort_homography.sv
// ----------------------------------------------------------------------------
// profile_undistort_homography
// laser profile sample undistortion and homography projection
// ----------------------------------------------------------------------------
// Loads (map entries, coefficients) are held off until no sample is queued or
// in the back end, so a load never overtakes an earlier sample. In the back
// end a sample goes through two dependent distortion map reads, nine
// coefficient terms (six products and three constants), then two 80-step
// bit-serial divisions, which set the sample rate. A two-entry queue sits
// between the front and back ends. The distortion map is undefined until
// written.
module profile_undistort_homography (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type, map_index, map_dx, map_dy, coef_index, coef_value, column,
  // range_value, zero padding
  input  logic [159:0] in_tdata,
  input  logic         in_tlast,   // end_of_profile
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_column, world_x, world_z, point_valid, zero padding
  output logic [79:0]  out_tdata,
  output logic         out_tlast   // out_last
);
  logic [10:0] width_r;
  logic [9:0]  height_r;
  logic [31:0] marker_r;
  puh_pkg::sample_t in_sample, q_sample;
  logic q_valid, q_ready, map_we, coef_we;
  logic [puh_pkg::AddrW-1:0] map_waddr, map_raddr;
  logic [47:0] map_wdata, map_rdata, coef_wdata, coef_rdata;
  logic [3:0]  coef_waddr, coef_raddr;
  logic [74:0] data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 10'd512;
      marker_r <= 32'h8000_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        puh_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[10:0];
        puh_pkg::CFG_HEIGHT: height_r <= cfg_wdata[9:0];
        puh_pkg::CFG_MARKER: marker_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_sample = '{column: in_tdata[130:121], range_value: in_tdata[154:131],
                       last: in_tlast};

  puh_front u_front (.clk, .rst_n, .in_tvalid, .in_tready,
    .req_type(in_tdata[1:0]), .map_index(in_tdata[20:2]), .map_dx(in_tdata[44:21]),
    .map_dy(in_tdata[68:45]), .coef_index(in_tdata[72:69]),
    .coef_value(in_tdata[120:73]), .in_sample, .back_idle(q_ready), .map_we,
    .map_waddr, .map_wdata, .coef_we, .coef_waddr, .coef_wdata, .q_valid, .q_ready,
    .q_sample);

  puh_ram #(.Width(48), .Depth(puh_pkg::Depth)) u_map (.clk, .we(map_we),
    .waddr(map_waddr), .wdata(map_wdata), .raddr(map_raddr), .rdata(map_rdata));
  puh_ram #(.Width(48), .Depth(16)) u_coef (.clk, .we(coef_we),
    .waddr(coef_waddr), .wdata(coef_wdata), .raddr(coef_raddr), .rdata(coef_rdata));

  puh_back u_back (.clk, .rst_n, .width_r, .height_r, .marker_r, .q_valid, .q_ready,
    .q_sample, .map_raddr, .map_rdata, .coef_raddr, .coef_rdata, .out_tvalid,
    .out_tready, .out_tdata(data), .out_tlast);

  assign out_tdata = {5'd0, data};
endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the profile undistortion and homography block:
// loads map entries and coefficients, streams profile samples under random
// stalls on both sides, and checks each point against a bit-true predictor
// ----------------------------------------------------------------------------
module tb;
  localparam int WatchLimit = 4000;
  localparam int DrainWait  = 300;
  localparam int PhaseItems = 110;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  req;
    logic [18:0] map_index;
    logic [23:0] dx;
    logic [23:0] dy;
    logic [3:0]  coef_index;
    logic [47:0] coef_value;
    logic [9:0]  column;
    logic [23:0] range_value;
    logic        last;
  } req_item_t;

  typedef struct {
    logic [9:0]  column;
    logic [31:0] wx;
    logic [31:0] wz;
    logic        valid;
    logic        last;
  } point_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;
  logic         out_tlast;

  profile_undistort_homography dut (.*);

  // shadow state
  logic [47:0] dist_map [int];
  logic [47:0] homog [9];
  logic [10:0] sh_width;
  logic [9:0]  sh_height;
  logic [31:0] sh_marker;

  point_t point_q [$];
  int     mismatches;
  int     n_items;
  int     n_points;
  int     n_invalid;
  int     idle_cycles;
  bit     in_burst;
  bit     out_burst;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint sx24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint sx48(logic [47:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint eff_width();
    return sh_width == 0 ? 1 :
           (sh_width > puh_pkg::MaxWidth ? puh_pkg::MaxWidth : sh_width);
  endfunction

  function automatic longint eff_height();
    return sh_height == 0 ? 1 :
           (sh_height > puh_pkg::MaxHeight ? puh_pkg::MaxHeight : sh_height);
  endfunction

  function automatic longint clamp_pix(longint c, longint bound);
    if (c < 0) return 0;
    if (c >= (bound <<< 11)) return bound - 1;
    return c >>> 11;
  endfunction

  function automatic int map_addr(longint cx, longint cy);
    return int'(clamp_pix(cy, eff_height()) * eff_width() + clamp_pix(cx, eff_width()));
  endfunction

  // Q.32 coefficient times Q.11 value, Q.32 result rounded down
  function automatic longint coef_mul(logic [47:0] coef, longint u);
    longint h;
    longint hh;
    longint hl;
    h  = sx48(coef);
    hh = h >>> 16;
    hl = h - hh * 65536;
    return hh * u * 32 + ((hl * u) >>> 11);
  endfunction

  function automatic logic [31:0] q16_divide(longint num, longint den);
    bit          neg;
    bit          sat;
    bit [63:0]   un;
    bit [63:0]   ud;
    bit [63:0]   r;
    bit [63:0]   q;
    bit [63:0]   lim;
    bit [79:0]   n;
    longint      res;
    neg = (num < 0) != (den < 0);
    un  = num < 0 ? 64'd0 - 64'(num) : 64'(num);
    ud  = den < 0 ? 64'd0 - 64'(den) : 64'(den);
    n   = {un, 16'd0};
    r   = 0;
    q   = 0;
    sat = 0;
    for (int i = 79; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q[0] = 1'b1;
      end
      if (q[63:40] != 0) begin
        sat = 1;
        q[63:40] = 0;
      end
    end
    if (r >= ud - r) q = q + 1;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (sat || q > lim) q = lim;
    res = neg ? -longint'(q) : longint'(q);
    return res[31:0];
  endfunction

  function automatic point_t project_sample(req_item_t it);
    point_t      p;
    longint      sx;
    longint      sy;
    longint      cx;
    longint      cy;
    longint      den;
    longint      nx;
    longint      nz;
    logic [47:0] e;
    sx = longint'(it.column) <<< 11;
    sy = longint'(it.range_value);
    cx = sx;
    cy = sy;
    for (int k = 0; k < 2; k++) begin
      e  = dist_map[map_addr(cx, cy)];
      cx = sx - sx24(e[23:0]);
      cy = sy - sx24(e[47:24]);
    end
    den = coef_mul(homog[6], cx) + coef_mul(homog[7], cy) + sx48(homog[8]);
    p.column = it.column;
    p.last   = it.last;
    p.valid  = it.range_value != 0 && den != 0;
    if (p.valid) begin
      nx = coef_mul(homog[0], cx) + coef_mul(homog[1], cy) + sx48(homog[2]);
      nz = coef_mul(homog[3], cx) + coef_mul(homog[4], cy) + sx48(homog[5]);
      p.wx = q16_divide(nx, den);
      p.wz = q16_divide(nz, den);
    end else begin
      p.wx = sh_marker;
      p.wz = sh_marker;
    end
    return p;
  endfunction

  function automatic req_item_t rand_item(logic [1:0] req);
    req_item_t it;
    it.req         = req;
    it.map_index   = 19'($urandom);
    it.dx          = 24'($urandom);
    it.dy          = 24'($urandom);
    it.coef_index  = 4'($urandom);
    it.coef_value  = {16'($urandom), 32'($urandom)};
    it.column      = 10'($urandom);
    it.range_value = 24'($urandom);
    it.last        = 1'($urandom);
    return it;
  endfunction

  // small offsets mostly, full range now and then
  function automatic logic [23:0] rand_offset();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 16384)) - 8192);
  endfunction

  function automatic logic [47:0] rand_coef();
    logic [47:0] v;
    v = {16'($urandom), 32'($urandom)};
    return 48'(signed'(v) >>> $urandom_range(0, 47));
  endfunction

  task automatic send_item(req_item_t it);
    int gap;
    if ($urandom_range(0, 19) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tdata  = {5'd0, it.range_value, it.column, it.coef_value, it.coef_index,
                 it.dy, it.dx, it.map_index, it.req};
    in_tlast  = it.last;
    in_tvalid = 1'b1;
    case (it.req)
      puh_pkg::REQ_MAP: begin
        dist_map[int'(it.map_index)] = {it.dy, it.dx};
      end
      puh_pkg::REQ_COEF: begin
        if (it.coef_index < 9) homog[it.coef_index] = it.coef_value;
      end
      puh_pkg::REQ_SAMPLE: begin
        point_q.push_back(project_sample(it));
      end
      default: ;
    endcase
    n_items++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_map(int addr, logic [23:0] dx, logic [23:0] dy);
    req_item_t it;
    it = rand_item(puh_pkg::REQ_MAP);
    it.map_index = 19'(addr);
    it.dx = dx;
    it.dy = dy;
    send_item(it);
  endtask

  task automatic load_coef(int k, logic [47:0] v);
    req_item_t it;
    it = rand_item(puh_pkg::REQ_COEF);
    it.coef_index = 4'(k);
    it.coef_value = v;
    send_item(it);
  endtask

  // writes any map entry the two passes would read before it is written
  task automatic send_sample(logic [9:0] col, logic [23:0] rng, logic last);
    req_item_t   it;
    int          a;
    logic [47:0] e;
    it = rand_item(puh_pkg::REQ_SAMPLE);
    it.column = col;
    it.range_value = rng;
    it.last = last;
    a = map_addr(longint'(col) <<< 11, longint'(rng));
    if (!dist_map.exists(a)) load_map(a, rand_offset(), rand_offset());
    e = dist_map[a];
    a = map_addr((longint'(col) <<< 11) - sx24(e[23:0]), longint'(rng) - sx24(e[47:24]));
    if (!dist_map.exists(a)) load_map(a, rand_offset(), rand_offset());
    send_item(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (point_q.size() == 0);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      puh_pkg::CFG_WIDTH:  sh_width  = val[10:0];
      puh_pkg::CFG_HEIGHT: sh_height = val[9:0];
      puh_pkg::CFG_MARKER: sh_marker = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_homography(bit sensible);
    for (int k = 0; k < 9; k++)
      load_coef(k, sensible ? rand_coef() : {16'($urandom), 32'($urandom)});
  endtask

  task automatic test_directed();
    req_item_t it;
    load_coef(0, 48'h0001_0000_0000);
    load_coef(1, 48'd0);
    load_coef(2, 48'h7FFF_FFFF_FFFF);
    load_coef(3, 48'd0);
    load_coef(4, 48'hFFFF_0000_0000);
    load_coef(5, 48'h8000_0000_0000);
    load_coef(6, 48'd0);
    load_coef(7, 48'd0);
    load_coef(8, 48'h0000_0800_0000);
    load_map(0, 24'h7FFFFF, 24'h800000);
    load_map(puh_pkg::Depth - 1, 24'h800000, 24'h7FFFFF);
    send_sample(10'd0, 24'd1, 1'b0);
    send_sample(10'd1023, 24'hFFFFFF, 1'b1);
    send_sample(10'd512, 24'd0, 1'b0);
    send_sample(10'd5, 24'd40000, 1'b1);
    // ignored requests: coefficient number past the table, unused request type
    it = rand_item(puh_pkg::REQ_COEF);
    it.coef_index = 4'd15;
    send_item(it);
    it = rand_item(puh_pkg::REQ_COEF);
    it.coef_index = 4'd9;
    send_item(it);
    send_item(rand_item(REQ_UNUSED));
    send_sample(10'd100, 24'd2048, 1'b0);
    // zero divisor
    load_coef(8, 48'd0);
    send_sample(10'd7, 24'd3000, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_phase(logic [10:0] w, logic [9:0] h, logic [31:0] marker);
    int        sel;
    req_item_t it;
    write_cfg(puh_pkg::CFG_WIDTH, 32'(w));
    write_cfg(puh_pkg::CFG_HEIGHT, 32'(h));
    write_cfg(puh_pkg::CFG_MARKER, marker);
    load_homography($urandom_range(0, 3) != 0);
    for (int n = 0; n < PhaseItems; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        if ($urandom_range(0, 4) == 0)
          send_sample(10'($urandom), 24'($urandom), 1'($urandom));
        else
          send_sample(10'($urandom_range(0, int'(eff_width() - 1))),
                      24'($urandom_range(0, int'(eff_height() * 2048))), 1'($urandom));
      end else if (sel < 85) begin
        if ($urandom_range(0, 1) == 0)
          load_map($urandom_range(0, int'(eff_width() * eff_height() - 1)),
                   rand_offset(), rand_offset());
        else
          send_item(rand_item(puh_pkg::REQ_MAP));
      end else if (sel < 90) begin
        load_coef($urandom_range(0, 8), rand_coef());
      end else if (sel < 96) begin
        send_item(rand_item(puh_pkg::REQ_COEF));
      end else begin
        it = rand_item(REQ_UNUSED);
        send_item(it);
      end
    end
    wait_idle();
  endtask

  // result checker
  always @(posedge clk) begin
    point_t exp_p;
    point_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.column = out_tdata[9:0];
      got.wx     = out_tdata[41:10];
      got.wz     = out_tdata[73:42];
      got.valid  = out_tdata[74];
      got.last   = out_tlast;
      if (point_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point: col %0d", got.column);
      end else begin
        exp_p = point_q.pop_front();
        n_points++;
        if (!exp_p.valid) n_invalid++;
        if (got.column !== exp_p.column || got.wx !== exp_p.wx || got.wz !== exp_p.wz ||
            got.valid !== exp_p.valid || got.last !== exp_p.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %h %h %b %b, got %0d %h %h %b %b",
                     exp_p.column, exp_p.wx, exp_p.wz, exp_p.valid, exp_p.last,
                     got.column, got.wx, got.wz, got.valid, got.last);
        end
      end
    end
  end

  // result-side stalls
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) out_burst = ~out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = puh_pkg::CFG_WIDTH;
    cfg_wdata   = 32'd0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    idle_cycles = 0;
    mismatches  = 0;
    n_items     = 0;
    n_points    = 0;
    n_invalid   = 0;
    in_burst    = 0;
    out_burst   = 0;
    sh_width    = 11'd1024;
    sh_height   = 10'd512;
    sh_marker   = 32'h8000_0000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(11'd1, 10'd1, 32'h7FFF_FFFF);
    test_random_phase(11'd0, 10'd0, 32'h0000_0000);
    test_random_phase(11'd2047, 10'd1023, 32'h8000_0000);
    test_random_phase(11'd1024, 10'd512, 32'hFFFF_FFFF);
    test_random_phase(11'd8, 10'd8, $urandom);
    test_random_phase(11'($urandom_range(1, 1024)), 10'($urandom_range(1, 512)), $urandom);
    test_random_phase(11'($urandom_range(1, 64)), 10'($urandom_range(1, 32)), $urandom);
    test_random_phase(11'($urandom_range(1, 2047)), 10'($urandom_range(0, 1023)), $urandom);

    $display("items sent %0d, points checked %0d (%0d invalid), mismatches %0d",
             n_items, n_points, n_invalid, mismatches);
    if (mismatches == 0 && point_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
